// ----- rtl/core/occupancy_grid_engine_core_defines.svh -----
// assertion macros for the occupancy grid engine
`ifndef OCCUPANCY_GRID_ENGINE_CORE_DEFINES_SVH
`define OCCUPANCY_GRID_ENGINE_CORE_DEFINES_SVH
`ifndef SYNTH
`define OGE_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("occupancy grid assertion failed");
`define OGE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("occupancy grid assertion failed");
`else
`define OGE_ASSERT_SAME(lbl, ante, cons)
`define OGE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/core/ogrid_pkg.sv -----
// shared constants and types of the occupancy grid engine
package ogrid_pkg;
   localparam int GRID_W_DEF  = 64;
   localparam int GRID_H_DEF  = 64;
   localparam int ID_BITS_DEF = 16;

   localparam logic [3:0] CMD_CLEAR   = 4'd0;
   localparam logic [3:0] CMD_ASSIGN  = 4'd1;
   localparam logic [3:0] CMD_POINT   = 4'd2;
   localparam logic [3:0] CMD_RECT    = 4'd3;
   localparam logic [3:0] CMD_LOOK_L  = 4'd4;
   localparam logic [3:0] CMD_LOOK_R  = 4'd5;
   localparam logic [3:0] CMD_LOOK_U  = 4'd6;
   localparam logic [3:0] CMD_LOOK_D  = 4'd7;
   localparam logic [3:0] CMD_SKIRT_L = 4'd8;
   localparam logic [3:0] CMD_SKIRT_R = 4'd9;
   localparam logic [3:0] CMD_SKIRT_U = 4'd10;
   localparam logic [3:0] CMD_SKIRT_D = 4'd11;

   localparam logic [1:0] DIR_L = 2'd0;
   localparam logic [1:0] DIR_R = 2'd1;
   localparam logic [1:0] DIR_U = 2'd2;
   localparam logic [1:0] DIR_D = 2'd3;

   localparam logic [1:0] PRB_CUR  = 2'd0;
   localparam logic [1:0] PRB_NEXT = 2'd1;
   localparam logic [1:0] PRB_NA   = 2'd2;
   localparam logic [1:0] PRB_NB   = 2'd3;

   typedef struct packed {
      logic       load;
      logic       rd_en;
      logic [1:0] probe_sel;
      logic       wr_sweep;
      logic       wr_cell;
      logic       row_next;
      logic       col_next;
      logic       step;
      logic       set_flag;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic [3:0] code;
      logic       sweep_last;
      logic       reject;
      logic       row_ok;
      logic       col_ok;
      logic       rect_bad;
      logic       pt_inside;
      logic       look_bound;
      logic       before_lim;
      logic       free;
      logic       moved;
   } sts_type;
endpackage

// ----- rtl/core/ogrid_ram.sv -----
// generic single write, single read ram with registered read data
module ogrid_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/core/ogrid_ctrl.sv -----
// controller state machine of the occupancy grid engine
module ogrid_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  ogrid_pkg::sts_type sts,
   output ogrid_pkg::cmd_type cmd
);
   import ogrid_pkg::*;

   localparam logic [3:0] ST_INIT    = 4'd0;
   localparam logic [3:0] ST_IDLE    = 4'd1;
   localparam logic [3:0] ST_DISP    = 4'd2;
   localparam logic [3:0] ST_WIPE    = 4'd3;
   localparam logic [3:0] ST_ASG     = 4'd4;
   localparam logic [3:0] ST_PT      = 4'd5;
   localparam logic [3:0] ST_RECT    = 4'd6;
   localparam logic [3:0] ST_RECT_WT = 4'd7;
   localparam logic [3:0] ST_LOOK    = 4'd8;
   localparam logic [3:0] ST_LOOK_WT = 4'd9;
   localparam logic [3:0] ST_SK      = 4'd10;
   localparam logic [3:0] ST_SK_N    = 4'd11;
   localparam logic [3:0] ST_SK_A    = 4'd12;
   localparam logic [3:0] ST_SK_B    = 4'd13;
   localparam logic [3:0] ST_DONE    = 4'd14;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_INIT: begin
            cmd.wr_sweep = 1'b1;
            if (sts.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DISP;
            end
         end
         ST_DISP: begin
            case (sts.code)
               CMD_CLEAR: state_in = ST_WIPE;
               CMD_ASSIGN: state_in = sts.reject ? ST_DONE : ST_ASG;
               CMD_POINT: begin
                  if (sts.pt_inside) begin
                     cmd.rd_en     = 1'b1;
                     cmd.probe_sel = PRB_CUR;
                     state_in      = ST_PT;
                  end else begin
                     cmd.set_flag = 1'b1;
                     state_in     = ST_DONE;
                  end
               end
               CMD_RECT: state_in = sts.rect_bad ? ST_DONE : ST_RECT;
               CMD_LOOK_L, CMD_LOOK_R, CMD_LOOK_U, CMD_LOOK_D: state_in = ST_LOOK;
               CMD_SKIRT_L, CMD_SKIRT_R, CMD_SKIRT_U, CMD_SKIRT_D: state_in = ST_SK;
               default: state_in = ST_DONE;
            endcase
         end
         ST_WIPE: begin
            cmd.wr_sweep = 1'b1;
            if (sts.sweep_last) begin
               state_in = ST_DONE;
            end
         end
         ST_ASG: begin
            cmd.probe_sel = PRB_CUR;
            if (!sts.row_ok) begin
               state_in = ST_DONE;
            end else if (sts.col_ok) begin
               cmd.wr_cell  = 1'b1;
               cmd.col_next = 1'b1;
            end else begin
               cmd.row_next = 1'b1;
            end
         end
         ST_PT: begin
            cmd.set_flag = sts.free;
            state_in     = ST_DONE;
         end
         ST_RECT: begin
            cmd.probe_sel = PRB_CUR;
            if (!sts.row_ok) begin
               state_in = ST_DONE;
            end else if (sts.col_ok) begin
               cmd.rd_en = 1'b1;
               state_in  = ST_RECT_WT;
            end else begin
               cmd.row_next = 1'b1;
            end
         end
         ST_RECT_WT: begin
            if (!sts.free) begin
               cmd.set_flag = 1'b1;
               state_in     = ST_DONE;
            end else begin
               cmd.col_next = 1'b1;
               state_in     = ST_RECT;
            end
         end
         ST_LOOK: begin
            cmd.probe_sel = PRB_CUR;
            if (sts.look_bound) begin
               cmd.rd_en = 1'b1;
               state_in  = ST_LOOK_WT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_LOOK_WT: begin
            if (sts.free) begin
               cmd.step = 1'b1;
               state_in = ST_LOOK;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SK: begin
            cmd.probe_sel = PRB_NEXT;
            if (sts.before_lim) begin
               cmd.rd_en = 1'b1;
               state_in  = ST_SK_N;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SK_N: begin
            cmd.probe_sel = PRB_NA;
            if (sts.free) begin
               cmd.rd_en = 1'b1;
               state_in  = ST_SK_A;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SK_A: begin
            cmd.probe_sel = PRB_NB;
            if (sts.free) begin
               cmd.rd_en = 1'b1;
               state_in  = ST_SK_B;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_SK;
            end
         end
         ST_SK_B: begin
            // fork ahead: one last step only after moving
            if (sts.free) begin
               cmd.step = sts.moved;
               state_in = ST_DONE;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_SK;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

// ----- rtl/core/ogrid_dp.sv -----
// datapath of the occupancy grid engine: operand registers, walkers and cell store
module ogrid_dp #(
   parameter int GRID_W  = 64,
   parameter int GRID_H  = 64,
   parameter int ID_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [3:0]        req_command,
   input  logic signed [7:0] req_x,
   input  logic signed [7:0] req_y,
   input  logic [6:0]        req_x_end,
   input  logic [6:0]        req_y_end,
   input  logic [6:0]        req_span_x,
   input  logic [6:0]        req_span_y,
   input  logic [15:0]       req_owner,
   input  logic signed [7:0] req_limit,
   input  ogrid_pkg::cmd_type cmd,
   output ogrid_pkg::sts_type sts,
   output logic              rsp_status,
   output logic              rsp_flag,
   output logic signed [7:0] rsp_coord
);
   import ogrid_pkg::*;

   localparam int MAXD  = (GRID_W > GRID_H) ? GRID_W : GRID_H;
   localparam int CW_R  = $clog2(MAXD + 2) + 1;
   localparam int CW    = (CW_R < 10) ? 10 : CW_R;
   localparam int DEPTH = GRID_W * GRID_H;
   localparam int AW    = $clog2(DEPTH);
   localparam int XB    = $clog2(GRID_W);
   localparam int YB    = $clog2(GRID_H);
   localparam logic signed [CW-1:0] W_S = CW'(GRID_W);
   localparam logic signed [CW-1:0] H_S = CW'(GRID_H);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [ID_BITS-1:0] EMPTY = '1;

   logic [3:0]               code_ff, code_in;
   logic signed [CW-1:0]     x0_ff, x0_in, y0_ff, y0_in;
   logic signed [CW-1:0]     cx_ff, cx_in, cy_ff, cy_in;
   logic signed [CW-1:0]     xe_ff, xe_in, ye_ff, ye_in, lim_ff, lim_in;
   logic [6:0]               sx_ff, sx_in, sy_ff, sy_in;
   logic [ID_BITS-1:0]       id_ff, id_in;
   logic                     moved_ff, moved_in, flag_ff, flag_in, pin_ff, pin_in;
   logic [AW-1:0]            sweep_ff, sweep_in;
   logic                     ostat_ff, ostat_in, oflag_ff, oflag_in;
   logic signed [7:0]        ocoord_ff, ocoord_in;

   logic [1:0]               dir;
   logic                     neg, horiz, is_walk;
   logic signed [CW-1:0]     dx, dy, ax, ay, nx, ny, px, py, axis, sx_s, sy_s;
   logic                     p_inside, reject;
   logic [AW-1:0]            row_base, paddr, wr_addr;
   logic [ID_BITS-1:0]       rd_data, wr_data;

   assign dir     = code_ff[1:0];
   assign neg     = (dir == DIR_L) || (dir == DIR_D);
   assign horiz   = (dir == DIR_L) || (dir == DIR_R);
   assign is_walk = code_ff[3] ^ code_ff[2];
   assign dx      = horiz ? (neg ? -CW'(1) : CW'(1)) : '0;
   assign dy      = horiz ? '0 : (neg ? -CW'(1) : CW'(1));
   assign ax      = horiz ? '0 : CW'(1);
   assign ay      = horiz ? CW'(1) : '0;
   assign nx      = cx_ff + dx;
   assign ny      = cy_ff + dy;
   assign axis    = horiz ? cx_ff : cy_ff;
   assign sx_s    = CW'(sx_ff);
   assign sy_s    = CW'(sy_ff);

   always_comb begin
      case (cmd.probe_sel)
         PRB_CUR: begin
            px = cx_ff;
            py = cy_ff;
         end
         PRB_NEXT: begin
            px = nx;
            py = ny;
         end
         PRB_NA: begin
            px = nx + ax;
            py = ny + ay;
         end
         default: begin
            px = nx - ax;
            py = ny - ay;
         end
      endcase
   end

   assign p_inside = (px >= 0) && (py >= 0) && (px < W_S) && (py < H_S);
   assign row_base = AW'(py[YB-1:0]) * AW'(GRID_W);
   assign paddr    = row_base + AW'(px[XB-1:0]);
   assign wr_addr  = cmd.wr_sweep ? sweep_ff : paddr;
   assign wr_data  = cmd.wr_sweep ? EMPTY : id_ff;
   assign reject   = !((x0_ff >= 0) && (y0_ff >= 0) && (x0_ff < W_S) && (y0_ff < H_S))
                     || (sx_s > W_S) || (sy_s > H_S);

   ogrid_ram #(
      .WIDTH (ID_BITS),
      .DEPTH (DEPTH)
   ) u_cells (
      .clock   (clock),
      .wr_en   (cmd.wr_sweep || cmd.wr_cell),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (paddr),
      .rd_data (rd_data)
   );

   always_comb begin
      sts            = '0;
      sts.code       = code_ff;
      sts.sweep_last = (sweep_ff == LAST_ADDR);
      sts.reject     = reject;
      if (code_ff == CMD_ASSIGN) begin
         sts.row_ok = (cy_ff < y0_ff + sy_s) && (cy_ff < H_S);
         sts.col_ok = (cx_ff < x0_ff + sx_s) && (cx_ff < W_S);
      end else begin
         sts.row_ok = (cy_ff <= ye_ff);
         sts.col_ok = (cx_ff <= xe_ff);
      end
      sts.rect_bad  = (x0_ff < 0) || (y0_ff < 0) || (xe_ff >= W_S) || (ye_ff >= H_S);
      sts.pt_inside = (x0_ff >= 0) && (y0_ff >= 0) && (x0_ff < W_S) && (y0_ff < H_S);
      case (dir)
         DIR_L: sts.look_bound = (cx_ff > 0);
         DIR_R: sts.look_bound = (cx_ff < W_S);
         DIR_U: sts.look_bound = (cy_ff < H_S);
         default: sts.look_bound = (cy_ff > 0);
      endcase
      sts.before_lim = neg ? (axis >= lim_ff) : (axis <= lim_ff);
      sts.free       = pin_ff && (rd_data == EMPTY);
      sts.moved      = moved_ff;
   end

   always_comb begin
      code_in   = code_ff;
      x0_in     = x0_ff;
      y0_in     = y0_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      xe_in     = xe_ff;
      ye_in     = ye_ff;
      lim_in    = lim_ff;
      sx_in     = sx_ff;
      sy_in     = sy_ff;
      id_in     = id_ff;
      moved_in  = moved_ff;
      flag_in   = flag_ff;
      pin_in    = pin_ff;
      sweep_in  = sweep_ff;
      ostat_in  = ostat_ff;
      oflag_in  = oflag_ff;
      ocoord_in = ocoord_ff;
      if (cmd.load) begin
         code_in  = req_command;
         x0_in    = CW'(req_x);
         y0_in    = CW'(req_y);
         cx_in    = CW'(req_x);
         cy_in    = CW'(req_y);
         xe_in    = CW'(req_x_end);
         ye_in    = CW'(req_y_end);
         lim_in   = CW'(req_limit);
         sx_in    = req_span_x;
         sy_in    = req_span_y;
         id_in    = ID_BITS'(req_owner);
         moved_in = 1'b0;
         flag_in  = 1'b0;
      end
      if (cmd.rd_en) begin
         pin_in = p_inside;
      end
      if (cmd.wr_sweep) begin
         sweep_in = (sweep_ff == LAST_ADDR) ? '0 : sweep_ff + AW'(1);
      end
      if (cmd.col_next) begin
         cx_in = cx_ff + CW'(1);
      end
      if (cmd.row_next) begin
         cx_in = x0_ff;
         cy_in = cy_ff + CW'(1);
      end
      if (cmd.step) begin
         cx_in    = nx;
         cy_in    = ny;
         moved_in = 1'b1;
      end
      if (cmd.set_flag) begin
         flag_in = 1'b1;
      end
      if (cmd.emit) begin
         ostat_in  = (code_ff == CMD_ASSIGN) && reject;
         oflag_in  = flag_ff;
         ocoord_in = is_walk ? axis[7:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else begin
         sweep_ff <= sweep_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff   <= code_in;
      x0_ff     <= x0_in;
      y0_ff     <= y0_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      xe_ff     <= xe_in;
      ye_ff     <= ye_in;
      lim_ff    <= lim_in;
      sx_ff     <= sx_in;
      sy_ff     <= sy_in;
      id_ff     <= id_in;
      moved_ff  <= moved_in;
      flag_ff   <= flag_in;
      pin_ff    <= pin_in;
      ostat_ff  <= ostat_in;
      oflag_ff  <= oflag_in;
      ocoord_ff <= ocoord_in;
   end

   assign rsp_status = ostat_ff;
   assign rsp_flag   = oflag_ff;
   assign rsp_coord  = ocoord_ff;
endmodule

// ----- rtl/core/occupancy_grid_engine_core.sv -----
// occupancy grid engine top level: controller, datapath and handshake
// point query reads one cell, look reads each cell walked, skirt reads up to three per step,
// rectangle query reads each cell row by row, assign writes each cell row by row, clear
// writes all GRID_W*GRID_H cells; one item at a time through the cell store
// reset: a clearing pass over all GRID_W*GRID_H cells empties the store, req_ready low until done
// a finished result waits in the output register while the next item is taken
`include "occupancy_grid_engine_core_defines.svh"
module occupancy_grid_engine_core #(
   parameter int GRID_W  = ogrid_pkg::GRID_W_DEF,
   parameter int GRID_H  = ogrid_pkg::GRID_H_DEF,
   parameter int ID_BITS = ogrid_pkg::ID_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [3:0]        req_command,
   input  logic signed [7:0] req_x,
   input  logic signed [7:0] req_y,
   input  logic [6:0]        req_x_end,
   input  logic [6:0]        req_y_end,
   input  logic [6:0]        req_span_x,
   input  logic [6:0]        req_span_y,
   input  logic [15:0]       req_owner,
   input  logic signed [7:0] req_limit,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_status,
   output logic              rsp_flag,
   output logic signed [7:0] rsp_coord
);
   import ogrid_pkg::*;

   cmd_type cmd;
   sts_type sts;

   ogrid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ogrid_dp #(
      .GRID_W  (GRID_W),
      .GRID_H  (GRID_H),
      .ID_BITS (ID_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_command (req_command),
      .req_x       (req_x),
      .req_y       (req_y),
      .req_x_end   (req_x_end),
      .req_y_end   (req_y_end),
      .req_span_x  (req_span_x),
      .req_span_y  (req_span_y),
      .req_owner   (req_owner),
      .req_limit   (req_limit),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_status  (rsp_status),
      .rsp_flag    (rsp_flag),
      .rsp_coord   (rsp_coord)
   );

   `OGE_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)
   `OGE_ASSERT_SAME(a_no_write_when_idle, cmd.wr_sweep || cmd.wr_cell, !req_ready)
   `OGE_ASSERT_SAME(a_no_read_on_write, cmd.rd_en, !(cmd.wr_sweep || cmd.wr_cell))
   `OGE_ASSERT_NEXT(a_emit_raises_valid, cmd.emit, rsp_valid)
endmodule

// ----- tb/tb_occupancy_grid_engine_core.sv -----
// self-checking testbench of the occupancy grid engine with a predicting scoreboard
module tb_occupancy_grid_engine_core;
   import ogrid_pkg::*;

   localparam int W = GRID_W_DEF;
   localparam int H = GRID_H_DEF;
   localparam int STALL_LIMIT = 30000;

   typedef struct {
      logic [3:0]        command;
      logic signed [7:0] x;
      logic signed [7:0] y;
      logic [6:0]        x_end;
      logic [6:0]        y_end;
      logic [6:0]        span_x;
      logic [6:0]        span_y;
      logic [15:0]       owner;
      logic signed [7:0] limit;
   } grid_req_type;

   typedef struct {
      logic       status;
      logic       flag;
      logic [7:0] coord;
   } grid_rsp_type;

   class grid_scoreboard;
      logic [15:0]  cells [W*H];
      grid_rsp_type answers [$];
      int           errors;

      function new();
         foreach (cells[i]) cells[i] = '1;
         errors = 0;
      endfunction

      function bit on_grid(int cx, int cy);
         return cx >= 0 && cy >= 0 && cx < W && cy < H;
      endfunction

      function bit is_free(int cx, int cy);
         if (!on_grid(cx, cy)) return 0;
         return cells[cy*W + cx] == 16'hFFFF;
      endfunction

      function bit fork_at(int nx, int ny, int ax, int ay);
         return is_free(nx + ax, ny + ay) && is_free(nx - ax, ny - ay);
      endfunction

      function bit within_bound(int cx, int cy, int dx, int dy, int lim);
         int c;
         c = (dx != 0) ? cx : cy;
         return (dx + dy < 0) ? (c >= lim) : (c <= lim);
      endfunction

      function int skirt_walk(int x, int y, int lim, int dx, int dy);
         int cx, cy, ax, ay;
         cx = x;
         cy = y;
         ax = (dy != 0);
         ay = (dx != 0);
         while (within_bound(cx, cy, dx, dy, lim) && is_free(cx + dx, cy + dy) &&
                !fork_at(cx + dx, cy + dy, ax, ay)) begin
            cx += dx;
            cy += dy;
         end
         if (fork_at(cx + dx, cy + dy, ax, ay) && (cx != x || cy != y) &&
             within_bound(cx, cy, dx, dy, lim) && is_free(cx + dx, cy + dy)) begin
            cx += dx;
            cy += dy;
         end
         return (dx != 0) ? cx : cy;
      endfunction

      function void note(grid_req_type r);
         grid_rsp_type e;
         int x, y, xe, ye, sx, sy, lim, c;
         x = r.x;
         y = r.y;
         xe = r.x_end;
         ye = r.y_end;
         sx = r.span_x;
         sy = r.span_y;
         lim = r.limit;
         e.status = 1'b0;
         e.flag = 1'b0;
         c = 0;
         case (r.command)
            CMD_CLEAR: foreach (cells[i]) cells[i] = '1;
            CMD_ASSIGN: begin
               if (!on_grid(x, y) || sx > W || sy > H) e.status = 1'b1;
               else
                  for (int j = y; j < y + sy && j < H; j++)
                     for (int i = x; i < x + sx && i < W; i++) cells[j*W + i] = r.owner;
            end
            CMD_POINT: e.flag = on_grid(x, y) ? is_free(x, y) : 1'b1;
            CMD_RECT: begin
               if (!(x < 0 || y < 0 || xe >= W || ye >= H))
                  for (int i = x; i <= xe; i++)
                     for (int j = y; j <= ye; j++)
                        if (!is_free(i, j)) e.flag = 1'b1;
            end
            CMD_LOOK_L: begin
               c = x;
               while (c > 0 && is_free(c, y)) c--;
            end
            CMD_LOOK_R: begin
               c = x;
               while (c < W && is_free(c, y)) c++;
            end
            CMD_LOOK_U: begin
               c = y;
               while (c < H && is_free(x, c)) c++;
            end
            CMD_LOOK_D: begin
               c = y;
               while (c > 0 && is_free(x, c)) c--;
            end
            CMD_SKIRT_L: c = skirt_walk(x, y, lim, -1, 0);
            CMD_SKIRT_R: c = skirt_walk(x, y, lim, 1, 0);
            CMD_SKIRT_U: c = skirt_walk(x, y, lim, 0, 1);
            CMD_SKIRT_D: c = skirt_walk(x, y, lim, 0, -1);
            default: ;
         endcase
         e.coord = c[7:0];
         answers.push_back(e);
      endfunction

      function void check(logic status, logic flag, logic [7:0] coord);
         grid_rsp_type e;
         if (answers.size() == 0) begin
            $display("%0t: unexpected transfer status=%0d flag=%0d coord=%0d",
                     $time, status, flag, coord);
            errors++;
            return;
         end
         e = answers.pop_front();
         if (status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, status);
            errors++;
         end
         if (flag !== e.flag) begin
            $display("%0t: flag expected %0d actual %0d", $time, e.flag, flag);
            errors++;
         end
         if (coord !== e.coord) begin
            $display("%0t: coord expected %0d actual %0d", $time,
                     $signed(e.coord), $signed(coord));
            errors++;
         end
      endfunction

      function int pending();
         return answers.size();
      endfunction
   endclass

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_ready;
   logic [3:0]        req_command = CMD_CLEAR;
   logic signed [7:0] req_x = 0;
   logic signed [7:0] req_y = 0;
   logic [6:0]        req_x_end = 0;
   logic [6:0]        req_y_end = 0;
   logic [6:0]        req_span_x = 0;
   logic [6:0]        req_span_y = 0;
   logic [15:0]       req_owner = 0;
   logic signed [7:0] req_limit = 0;
   logic              rsp_valid;
   logic              rsp_ready = 0;
   logic              rsp_status;
   logic              rsp_flag;
   logic signed [7:0] rsp_coord;

   grid_scoreboard sb = new();
   bit calm = 0;
   int hold_cycles = 0;
   int quiet_cycles = 0;

   occupancy_grid_engine_core dut (.*);

   initial forever #5 clock = ~clock;

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready = 0;
         hold_cycles--;
      end else begin
         rsp_ready = calm || ($urandom_range(0, 99) >= 31);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check(rsp_status, rsp_flag, rsp_coord);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_occupancy_grid_engine_core: errors");
         $finish;
      end
   end

   task automatic send_item(grid_req_type r);
      while (!calm && $urandom_range(0, 99) < 31) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid = 1;
      req_command = r.command;
      req_x = r.x;
      req_y = r.y;
      req_x_end = r.x_end;
      req_y_end = r.y_end;
      req_span_x = r.span_x;
      req_span_y = r.span_y;
      req_owner = r.owner;
      req_limit = r.limit;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note(r);
      @(negedge clock);
   endtask

   task automatic send_cmd(logic [3:0] cmd, int x, int y, int xe = 0, int ye = 0,
                           int sx = 0, int sy = 0, int owner = 0, int lim = 0);
      grid_req_type r;
      r.command = cmd;
      r.x = 8'(x);
      r.y = 8'(y);
      r.x_end = 7'(xe);
      r.y_end = 7'(ye);
      r.span_x = 7'(sx);
      r.span_y = 7'(sy);
      r.owner = 16'(owner);
      r.limit = 8'(lim);
      send_item(r);
   endtask

   function automatic int pick_coord();
      if ($urandom_range(0, 99) < 10) return $urandom_range(0, 255) - 128;
      return $urandom_range(0, 63);
   endfunction

   function automatic grid_req_type random_item();
      grid_req_type r;
      int sel;
      sel = $urandom_range(0, 99);
      r.x = 8'(pick_coord());
      r.y = 8'(pick_coord());
      r.x_end = 7'($urandom_range(0, 127));
      r.y_end = 7'($urandom_range(0, 127));
      r.span_x = 7'($urandom_range(0, 127));
      r.span_y = 7'($urandom_range(0, 127));
      r.owner = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom);
      r.limit = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, 65) - 1);
      if (sel < 1) r.command = CMD_CLEAR;
      else if (sel < 22) begin
         r.command = CMD_ASSIGN;
         if ($urandom_range(0, 9) != 0) begin
            r.span_x = 7'($urandom_range(0, 10));
            r.span_y = 7'($urandom_range(0, 10));
         end
      end else if (sel < 36) r.command = CMD_POINT;
      else if (sel < 46) begin
         r.command = CMD_RECT;
         if ($urandom_range(0, 19) != 0 && r.x >= 0 && r.y >= 0) begin
            r.x_end = 7'(r.x + $urandom_range(0, 6));
            r.y_end = 7'(r.y + $urandom_range(0, 6));
         end
      end else if (sel < 70) r.command = 4'(CMD_LOOK_L + $urandom_range(0, 3));
      else if (sel < 98) r.command = 4'(CMD_SKIRT_L + $urandom_range(0, 3));
      else r.command = 4'($urandom_range(12, 15));
      return r;
   endfunction

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      send_cmd(CMD_POINT, 0, 0);
      send_cmd(CMD_LOOK_R, 0, 10);
      send_cmd(CMD_ASSIGN, 63, 63, 0, 0, 64, 64, 16'h0000);
      send_cmd(CMD_ASSIGN, -1, 5, 0, 0, 2, 2, 16'h1234);
      send_cmd(CMD_ASSIGN, 5, 5, 0, 0, 65, 2, 16'h1234);
      send_cmd(CMD_ASSIGN, 5, 5, 0, 0, 0, 0, 16'h1234);
      send_cmd(CMD_ASSIGN, 10, 10, 0, 0, 3, 20, 16'hFFFE);
      send_cmd(CMD_ASSIGN, 10, 12, 0, 0, 3, 2, 16'hFFFF);
      send_cmd(CMD_POINT, -128, 127);
      send_cmd(CMD_POINT, 63, 63);
      send_cmd(CMD_RECT, 0, 0, 63, 63);
      send_cmd(CMD_RECT, 20, 5, 10, 30);
      send_cmd(CMD_RECT, 0, 0, 100, 5);
      send_cmd(CMD_LOOK_L, 30, 11);
      send_cmd(CMD_LOOK_U, 11, 0);
      send_cmd(CMD_LOOK_D, 40, 63);
      send_cmd(CMD_LOOK_R, 127, -128);
      send_cmd(CMD_SKIRT_R, 0, 9, 0, 0, 0, 0, 0, 64);
      send_cmd(CMD_SKIRT_L, 40, 9, 0, 0, 0, 0, 0, -1);
      send_cmd(CMD_SKIRT_U, 9, 0, 0, 0, 0, 0, 0, 20);
      send_cmd(CMD_SKIRT_D, 13, 40, 0, 0, 0, 0, 0, -128);
      send_cmd(CMD_SKIRT_R, -5, 3, 0, 0, 0, 0, 0, 127);
      send_cmd(4'd12, 1, 1);
      send_cmd(4'd15, -1, -1);
      send_cmd(CMD_CLEAR, 0, 0);

      for (int n = 0; n < 1300; n++) begin
         if (n == 300) hold_cycles = 400;
         if (n == 700) begin
            req_valid = 0;
            while (sb.pending() != 0) @(negedge clock);
         end
         calm = (n >= 900 && n < 1100);
         send_item(random_item());
      end
      req_valid = 0;
      calm = 0;

      while (sb.pending() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (sb.errors == 0) $display("tb_occupancy_grid_engine_core: clean");
      else $display("tb_occupancy_grid_engine_core: errors");
      $finish;
   end
endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/ogrid_pkg.sv
rtl/core/ogrid_ram.sv
rtl/core/ogrid_ctrl.sv
rtl/core/ogrid_dp.sv
rtl/core/occupancy_grid_engine_core.sv
tb/tb_occupancy_grid_engine_core.sv
